// ===== rtl/mixed_radix_index_converter_macros.svh =====
// Assertion macros for the index converter checker
`ifndef MIXED_RADIX_INDEX_CONVERTER_MACROS_SVH
`define MIXED_RADIX_INDEX_CONVERTER_MACROS_SVH
`define MRIC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MRIC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ===== rtl/mric_pkg.sv =====
// ----------------------------------------------------------------------------
// mric_pkg
// Shared types and constants for the mixed-radix index converter.
// ----------------------------------------------------------------------------
package mric_pkg;
   localparam int NUM_REG_DIMS = 3;
   localparam int MAX_EXTENT   = 1024;
   localparam logic CMD_TO_INDEX = 1'b0;
   localparam logic CMD_TO_COORD = 1'b1;
   localparam logic [2:0] REG_DIMS = 3'd0;
   localparam logic [2:0] REG_LB0  = 3'd1;
   localparam logic [2:0] REG_LB1  = 3'd2;
   localparam logic [2:0] REG_LB2  = 3'd3;
   localparam logic [2:0] REG_EXT0 = 3'd4;
   localparam logic [2:0] REG_EXT1 = 3'd5;
   localparam logic [2:0] REG_EXT2 = 3'd6;

   typedef struct packed {
      logic               command;
      logic [2:0][15:0]   coord;
      logic [29:0]        index;
   } item_type;

   typedef struct packed {
      logic [29:0]        index;
      logic [2:0][15:0]   coord;
      logic [30:0]        size;
      logic               oor;
   } result_type;

   // Effective configuration, with a reciprocal ceil(2^(30+shift)/ext) and
   // its shift per extent, rebuilt after every write.
   typedef struct packed {
      logic [1:0]         dims;
      logic [2:0][15:0]   lb;
      logic [2:0][10:0]   ext;
      logic [2:0][31:0]   recip;
      logic [2:0][3:0]    shift;
   } cfg_type;
endpackage

// ===== rtl/mixed_radix_index_converter.sv =====
// rsp_tvalid rises once an accepted req has passed its queue slot and 5 stages.
// Throughput: one item per cycle; the pipeline stalls as a whole on rsp_tready.
// After any csr write req_tready is held low while reciprocals rebuild.
// The multiply-by-reciprocal stages, one per trailing dimension, set the depth.
// Reset (synchronous, high) empties queue and pipe; registers take reset values.
// ----------------------------------------------------------------------------
// mixed_radix_index_converter
// Row-major coordinate/index converter over a configured box domain.
// ----------------------------------------------------------------------------
module mixed_radix_index_converter import mric_pkg::*; #(
   parameter int MAX_DIMS = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[0], coord_in_0[16:1], coord_in_1[32:17], coord_in_2[48:33],
   // index_in[78:49], zero pad
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // index_out[29:0], coord_out_0[45:30], coord_out_1[61:46],
   // coord_out_2[77:62], domain_size[108:78], out_of_range[109], zero pad
   output logic [111:0] rsp_tdata
);
   item_type   it, q_item;
   cfg_type    cfg;
   result_type res;
   logic       q_valid, q_ready;

   assign it.command = req_tdata[0];
   assign it.coord   = {req_tdata[48:33], req_tdata[32:17], req_tdata[16:1]};
   assign it.index   = req_tdata[78:49];

   mric_front #(.MAX_DIMS(MAX_DIMS)) u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(it),
      .q_valid, .q_ready, .q_item, .cfg
   );

   mric_back u_back (
      .clock, .reset, .cfg, .in_valid(q_valid), .in_ready(q_ready),
      .in_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_res(res)
   );

   assign rsp_tdata = {2'b00, res.oor, res.size, res.coord[2], res.coord[1],
                       res.coord[0], res.index};
endmodule

// ===== rtl/mric_front.sv =====
// ----------------------------------------------------------------------------
// mric_front
// Register bank, extent reciprocal builder and a two-entry input queue
// decoupling the front from the arithmetic back end.
// ----------------------------------------------------------------------------
module mric_front import mric_pkg::*; #(
   parameter int MAX_DIMS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        q_valid,
   input  logic        q_ready,
   output item_type    q_item,
   output cfg_type     cfg
);
   localparam logic [5:0] RECIP_LAST = 6'd39;

   logic [1:0]        dims_ff;
   logic [2:0][15:0]  lb_ff;
   logic [2:0][10:0]  ext_ff;
   item_type [1:0]    q_ff;
   logic              rd_ff, wr_ff;
   logic [1:0]        cnt_ff;
   logic              push, pop;
   logic              busy_ff;
   logic [5:0]        step_ff;
   logic [2:0][10:0]  rem_ff;
   logic [2:0][31:0]  quo_ff;
   logic [2:0][31:0]  recip_ff;
   logic [2:0][3:0]   lg_ff;
   logic [2:0][3:0]   lg;
   logic [2:0][10:0]  rem_in;
   logic [2:0][31:0]  quo_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 2'd1;
         lb_ff   <= '0;
         ext_ff  <= {3{11'd1}};
      end else if (csr_valid) begin
         if (csr_index == REG_DIMS) dims_ff <= csr_data[1:0];
         else if (csr_index >= REG_LB0 && csr_index <= REG_LB2)
            lb_ff[2'(csr_index - REG_LB0)] <= csr_data;
         else if (csr_index >= REG_EXT0 && csr_index <= REG_EXT2)
            ext_ff[2'(csr_index - REG_EXT0)] <= csr_data[10:0];
      end
   end

   always_comb begin
      logic [2:0] n;
      n = (dims_ff == 2'd0) ? 3'd1 : {1'b0, dims_ff};
      if (n > 3'(MAX_DIMS)) n = 3'(MAX_DIMS);
      if (n > 3'(NUM_REG_DIMS)) n = 3'(NUM_REG_DIMS);
      cfg.dims  = n[1:0];
      cfg.lb    = lb_ff;
      cfg.recip = recip_ff;
      cfg.shift = lg_ff;
      for (int k = 0; k < NUM_REG_DIMS; k++) begin
         if (ext_ff[k] == 11'd0) cfg.ext[k] = 11'd1;
         else if (ext_ff[k] > 11'(MAX_EXTENT)) cfg.ext[k] = 11'(MAX_EXTENT);
         else cfg.ext[k] = ext_ff[k];
         if (k >= int'(n)) cfg.ext[k] = 11'd1;
      end
   end

   // One restoring step per cycle of (2^(30+lg) - 1) / ext, bit 39 first
   always_comb begin
      logic [11:0] t;
      logic        b;
      for (int k = 0; k < NUM_REG_DIMS; k++) begin
         lg[k] = 4'd0;
         for (int j = 0; j < 11; j++)
            if ((11'd1 << j) < cfg.ext[k]) lg[k] = 4'(j + 1);
         b = (RECIP_LAST - step_ff) < (6'd30 + 6'(lg[k]));
         t = {rem_ff[k], b};
         if (t >= {1'b0, cfg.ext[k]}) begin
            rem_in[k] = 11'(t - {1'b0, cfg.ext[k]});
            quo_in[k] = {quo_ff[k][30:0], 1'b1};
         end else begin
            rem_in[k] = t[10:0];
            quo_in[k] = {quo_ff[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         rem_ff   <= '0;
         quo_ff   <= '0;
         recip_ff <= {3{32'h4000_0000}};
         lg_ff    <= '0;
      end else if (csr_valid) begin
         // any write may move an effective extent: rebuild all three
         busy_ff <= 1'b1;
         step_ff <= '0;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff + 6'd1;
         if (step_ff == RECIP_LAST) begin
            busy_ff <= 1'b0;
            for (int k = 0; k < NUM_REG_DIMS; k++) begin
               recip_ff[k] <= quo_in[k] + 32'd1;
               lg_ff[k]    <= lg[k];
            end
         end
      end
   end

   assign in_ready = (cnt_ff != 2'd2) && !busy_ff;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = q_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_item;
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/mric_back.sv =====
// ----------------------------------------------------------------------------
// mric_back
// Pipelined conversion: stride/offset stage, product stage, reciprocal
// division stages per dimension, result register.
// ----------------------------------------------------------------------------
module mric_back import mric_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);
   // Stages: s1 offsets/check, s2 products and idx / ext2, s3 remainder by
   // ext2 and quotient / ext1, s4 remainder by ext1, s5 result.
   // Whole pipe stalls together.
   localparam int NS = 5;
   logic [NS-1:0] v_ff;
   logic          adv;
   result_type    res_ff;

   assign adv       = !v_ff[NS-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = v_ff[NS-1];
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], in_valid};
   end

   // Stage 1
   logic              c1_ff, oor1_ff;
   logic [2:0][10:0]  off1_ff;
   logic [29:0]       idx1_ff;
   logic [21:0]       e12_ff;
   always_ff @(posedge clock) if (adv) begin
      logic o;
      logic signed [16:0] d;
      o = 1'b0;
      for (int k = 0; k < NUM_REG_DIMS; k++) begin
         d = $signed({in_item.coord[k][15], in_item.coord[k]})
           - $signed({cfg.lb[k][15], cfg.lb[k]});
         // inactive dimensions add nothing to the index
         off1_ff[k] <= (k < int'(cfg.dims)) ? d[10:0] : 11'd0;
         if (k < int'(cfg.dims) && (d < 0 || d >= $signed({6'd0, cfg.ext[k]}))) o = 1'b1;
      end
      c1_ff   <= in_item.command;
      oor1_ff <= o;
      idx1_ff <= in_item.index;
      e12_ff  <= cfg.ext[1] * cfg.ext[2];
   end

   // Stage 2
   logic        c2_ff, oor2_ff;
   logic [29:0] idx2_ff, lin2_ff, q2_ff;
   logic [30:0] size2_ff;
   always_ff @(posedge clock) if (adv) begin
      logic [30:0] a;
      logic [61:0] p;
      a = 31'(off1_ff[0] * e12_ff) + 31'(off1_ff[1] * cfg.ext[2]) + 31'(off1_ff[2]);
      p = {32'd0, idx1_ff} * {30'd0, cfg.recip[2]};
      p = p >> (6'd30 + 6'(cfg.shift[2]));
      c2_ff   <= c1_ff;
      idx2_ff <= idx1_ff;
      q2_ff   <= p[29:0];
      lin2_ff <= a[29:0];
      size2_ff <= 31'(cfg.ext[0] * e12_ff);
      oor2_ff <= c1_ff ? (31'(idx1_ff) >= 31'(cfg.ext[0] * e12_ff)) : oor1_ff;
   end

   // Stage 3: remainder by ext2, divide by ext1
   logic        c3_ff, oor3_ff;
   logic [29:0] q3_ff, q1_ff, lin3_ff;
   logic [10:0] r2_ff;
   logic [30:0] size3_ff;
   always_ff @(posedge clock) if (adv) begin
      logic [61:0] p;
      p = {32'd0, q2_ff} * {30'd0, cfg.recip[1]};
      p = p >> (6'd30 + 6'(cfg.shift[1]));
      c3_ff <= c2_ff; oor3_ff <= oor2_ff; lin3_ff <= lin2_ff; size3_ff <= size2_ff;
      q3_ff <= q2_ff;
      q1_ff <= p[29:0];
      r2_ff <= 11'(idx2_ff - 30'(q2_ff * cfg.ext[2]));
   end

   // Stage 4: remainder by ext1
   logic        c4_ff, oor4_ff;
   logic [29:0] lin4_ff;
   logic [10:0] r1_ff, r2b_ff, r0_ff;
   logic [30:0] size4_ff;
   always_ff @(posedge clock) if (adv) begin
      c4_ff <= c3_ff; oor4_ff <= oor3_ff; lin4_ff <= lin3_ff; size4_ff <= size3_ff;
      r2b_ff <= r2_ff;
      r1_ff <= 11'(q3_ff - 30'(q1_ff * cfg.ext[1]));
      r0_ff <= q1_ff[10:0];
   end

   // Stage 5: add bounds, saturate
   always_ff @(posedge clock) if (adv) begin
      logic o;
      logic [2:0][10:0] r;
      logic signed [17:0] c;
      o = oor4_ff;
      r = {r2b_ff, r1_ff, r0_ff};
      res_ff.size  <= size4_ff;
      res_ff.index <= (!c4_ff && !oor4_ff) ? lin4_ff : '0;
      for (int k = 0; k < NUM_REG_DIMS; k++) begin
         c = $signed({{2{cfg.lb[k][15]}}, cfg.lb[k]}) + $signed({7'd0, r[k]});
         if (!c4_ff || oor4_ff || k >= int'(cfg.dims)) res_ff.coord[k] <= '0;
         else if (c > 18'sd32767) begin
            res_ff.coord[k] <= 16'h7fff; o = 1'b1;
         end else res_ff.coord[k] <= c[15:0];
      end
      res_ff.oor <= o;
   end
endmodule

// ===== rtl/mric_checker.sv =====
// ----------------------------------------------------------------------------
// mric_checker
// Port-level checks on the converter's handshakes and results.
// ----------------------------------------------------------------------------
`include "mixed_radix_index_converter_macros.svh"
module mric_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic         csr_ready
);
   `MRIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")
   `MRIC_ASSERT_IMPL(a_size_nz, clock, reset, !rsp_tvalid || rsp_tdata[108:78] != 31'd0, "zero domain size")
   `MRIC_ASSERT_IMPL(a_oor_idx, clock, reset, !rsp_tvalid || !rsp_tdata[109] || rsp_tdata[29:0] == 30'd0, "index given with out of range")
   `MRIC_ASSERT_IMPL(a_csr_rdy, clock, reset, csr_ready, "config port not ready")
endmodule

bind mixed_radix_index_converter mric_checker u_mric_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_ready
);

// ===== dv/mixed_radix_index_converter_test.sv =====
// ----------------------------------------------------------------------------
// Mixed-radix index converter testbench
// Runs coordinate-to-index and index-to-coordinate requests through the block
// under several domain settings. Expected words are computed alongside and
// compared field by field with each accepted response.
// ----------------------------------------------------------------------------
module mixed_radix_index_converter_test import mric_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIMS = 3;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [29:0] index;
      logic [15:0] coord [3];
      logic [30:0] size;
      logic        oor;
   } conversion_type;

   class conversion_board;
      logic [1:0]     dims_reg;
      logic [15:0]    lb_reg [3];
      logic [10:0]    ext_reg [3];
      conversion_type pending [$];
      int             mismatches;
      int             checked;

      function void set_register(logic [2:0] idx, logic [15:0] val);
         if (idx == REG_DIMS) dims_reg = val[1:0];
         else if (idx >= REG_LB0 && idx <= REG_LB2) lb_reg[2'(idx - REG_LB0)] = val;
         else if (idx >= REG_EXT0 && idx <= REG_EXT2)
            ext_reg[2'(idx - REG_EXT0)] = val[10:0];
      endfunction

      function void clear();
         dims_reg = 2'd1;
         for (int k = 0; k < 3; k++) begin
            lb_reg[k] = '0;
            ext_reg[k] = 11'd1;
         end
      endfunction

      function int extent_of(int k);
         int e;
         e = int'(ext_reg[k]);
         if (e == 0) e = 1;
         if (e > MAX_EXTENT) e = MAX_EXTENT;
         return e;
      endfunction

      function void note_request(logic [79:0] word);
         conversion_type r;
         int             n;
         longint         size, acc, idx;
         int             off, e, c;
         n = int'(dims_reg);
         if (n < 1) n = 1;
         if (n > MAX_DIMS) n = MAX_DIMS;
         size = 1;
         for (int k = 0; k < n; k++) size *= extent_of(k);
         r.index = '0;
         r.oor = 1'b0;
         for (int k = 0; k < 3; k++) r.coord[k] = '0;
         if (word[0] == CMD_TO_INDEX) begin
            acc = 0;
            for (int k = 0; k < n; k++) begin
               off = int'($signed(word[1 + 16*k +: 16])) - int'($signed(lb_reg[k]));
               e = extent_of(k);
               if (off < 0 || off >= e) begin
                  r.oor = 1'b1;
                  break;
               end
               acc = acc * e + off;
            end
            if (!r.oor) r.index = acc[29:0];
         end else begin
            idx = longint'(word[78:49]);
            if (idx >= size) r.oor = 1'b1;
            else begin
               for (int k = n - 1; k >= 0; k--) begin
                  e = extent_of(k);
                  c = int'($signed(lb_reg[k])) + int'(idx % e);
                  idx = idx / e;
                  if (c > 32767) begin
                     c = 32767;
                     r.oor = 1'b1;
                  end
                  r.coord[k] = c[15:0];
               end
            end
         end
         r.size = size[30:0];
         pending = {pending, r};
      endfunction

      function void check_response(logic [111:0] word);
         conversion_type x;
         bit             bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", word);
            return;
         end
         x = pending.pop_front();
         checked++;
         bad = (word[29:0] !== x.index) || (word[45:30] !== x.coord[0])
            || (word[61:46] !== x.coord[1]) || (word[77:62] !== x.coord[2])
            || (word[108:78] !== x.size) || (word[109] !== x.oor)
            || (word[111:110] !== 2'b00);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("mismatch: exp idx %0d c %h %h %h size %0d oor %b, ",
                  x.index, x.coord[0], x.coord[1], x.coord[2], x.size, x.oor);
               $display("got idx %0d c %h %h %h size %0d oor %b pad %b",
                  word[29:0], word[45:30], word[61:46], word[77:62], word[108:78],
                  word[109], word[111:110]);
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;

   conversion_board board;
   bit  quiet_tail;
   int  cycles;
   int  sent;
   int  oor_seen;

   always #5 clock = ~clock;

   mixed_radix_index_converter #(.MAX_DIMS(MAX_DIMS)) dut (.*);

   // count cycles and watch for a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side: accept, check, and stall in random bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (rsp_tdata[109]) oor_seen++;
            board.check_response(rsp_tdata);
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_register(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, val);
   endtask

   task automatic send_request(logic [79:0] word);
      int gap;
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      board.note_request(word);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [79:0] to_index_word(int c0, int c1, int c2);
      logic [79:0] w;
      w = 80'({$urandom, $urandom, $urandom});
      w[0] = CMD_TO_INDEX;
      w[16:1] = c0[15:0];
      w[32:17] = c1[15:0];
      w[48:33] = c2[15:0];
      w[79] = 1'b0;
      return w;
   endfunction

   function automatic logic [79:0] to_coord_word(int idx);
      logic [79:0] w;
      w = 80'({$urandom, $urandom, $urandom});
      w[0] = CMD_TO_COORD;
      w[78:49] = idx[29:0];
      w[79] = 1'b0;
      return w;
   endfunction

   // random request: mostly within or near the domain, some raw noise
   function automatic logic [79:0] random_word();
      int c [3];
      int sz;
      sz = 1;
      for (int k = 0; k < 3; k++) begin
         c[k] = $signed(board.lb_reg[k]) + $urandom_range(0, board.extent_of(k) + 1) - 1;
         if ($urandom_range(0, 15) == 0) c[k] = $urandom;
         if (k < board.dims_reg || k == 0) sz *= board.extent_of(k);
      end
      case ($urandom_range(0, 5))
         0: return to_coord_word($urandom);
         1, 2: return to_coord_word($urandom_range(0, sz + 1));
         3: return to_index_word($urandom, $urandom, $urandom);
         default: return to_index_word(c[0], c[1], c[2]);
      endcase
   endfunction

   task automatic configure(int dims, int lb0, int lb1, int lb2, int e0, int e1, int e2);
      write_register(REG_DIMS, 16'(dims));
      write_register(REG_LB0, 16'(lb0));
      write_register(REG_LB1, 16'(lb1));
      write_register(REG_LB2, 16'(lb2));
      write_register(REG_EXT0, 16'(e0));
      write_register(REG_EXT1, 16'(e1));
      write_register(REG_EXT2, 16'(e2));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_dims, e [3], lb [3];
      board = new();
      board.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset domain, then extremes and saturating cases
      send_request(to_index_word(0, 0, 0));
      send_request(to_coord_word(0));
      send_request(to_coord_word(32'h3fffffff));
      drain();
      configure(3, -32768, 5, 32767, 1024, 1024, 1024);
      send_request(to_index_word(-32768, 5, 32767));
      send_request(to_index_word(-32768 + 1023, 5 + 1023, 32767));
      send_request(to_index_word(-32768 + 1023, 5 + 1023, -32768));
      send_request(to_index_word(-32768, 4, 32767));
      send_request(to_index_word(32767, 5, 32767));
      send_request(to_coord_word(32'h3fffffff));
      send_request(to_coord_word(0));
      send_request(to_coord_word(1));
      send_request(to_coord_word(1025));
      drain();
      // zero dimension count and zero and oversized extents
      configure(0, 32767, 32000, -1, 0, 2047, 2000);
      send_request(to_coord_word(0));
      send_request(to_coord_word(1));
      send_request(to_index_word(32767, 0, 0));
      send_request(to_index_word(32766, 0, 0));
      drain();
      configure(2, 32000, 32767, 0, 1024, 2047, 7);
      send_request(to_coord_word(1047551));
      send_request(to_coord_word(1048575));
      send_request(to_coord_word(1048576));
      send_request(to_index_word(32000, 32767 + 1023, 0));
      send_request(to_index_word(-1, -1, -1));
      // pause until every expected word is back
      drain();

      for (int p = 0; p < 14; p++) begin
         phase_dims = $urandom_range(0, 3);
         for (int k = 0; k < 3; k++) begin
            e[k] = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 12);
            lb[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(32700, 32767)
                  : $signed(16'($urandom));
         end
         configure(phase_dims, lb[0], lb[1], lb[2], e[0], e[1], e[2]);
         if (p >= 12) quiet_tail = 1'b1;
         repeat (58) send_request(random_word());
         drain();
      end

      $display("covered %0d requests over 18 domain settings, %0d flagged out of range",
         sent, oor_seen);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d words outstanding", board.mismatches,
            board.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
